/* src/sha224_pkg.sv */
// SHA-224 package: round constants, initial vector and the round helper functions.
// Used by the compression core and the top level; no dependencies.
package sha224_pkg;

  localparam logic [31:0] IV [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t a);
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic word_t big_s1(input word_t e);
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic word_t small_s0(input word_t b);
    small_s0 = rotr(b, 7) ^ rotr(b, 18) ^ (b >> 3);
  endfunction

  function automatic word_t small_s1(input word_t a);
    small_s1 = rotr(a, 17) ^ rotr(a, 19) ^ (a >> 10);
  endfunction

endpackage

/* src/sha224_core.sv */
// SHA-224 compression core: one round per cycle for the 64 rounds, then a fold
// step that adds the working variables into the chaining state. Uses sha224_pkg.
module sha224_core import sha224_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        init,       // reload the initial vector
  input  word_t       block_in [16],
  output word_t       hash_out [8],
  output logic        busy
);

  word_t hs [8];
  word_t v  [8];
  word_t sched [16];
  logic [5:0] rnd;
  logic       running;
  logic       folding;

  word_t w_t, t1, t2;
  word_t a, e;

  always_comb begin
    a = v[0];
    e = v[4];
    if (rnd < 6'd16) begin
      w_t = block_in[rnd[3:0]];
    end else begin
      w_t = small_s1(sched[4'(rnd - 6'd2)]) + sched[4'(rnd - 6'd7)]
          + small_s0(sched[4'(rnd - 6'd15)]) + sched[rnd[3:0]];
    end
    t1 = v[7] + big_s1(e) + ((e & v[5]) ^ (~e & v[6])) + ROUND_K[rnd] + w_t;
    t2 = big_s0(a) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      folding <= 1'b0;
      rnd     <= '0;
      hs      <= IV;
    end else if (init) begin
      hs <= IV;
    end else if (start) begin
      running <= 1'b1;
      rnd     <= '0;
      v       <= hs;
    end else if (running) begin
      sched[rnd[3:0]] <= w_t;
      for (int i = 7; i > 0; i--) v[i] <= v[i-1];
      v[0] <= t1 + t2;
      v[4] <= v[3] + t1;
      rnd  <= rnd + 6'd1;
      if (rnd == 6'd63) begin
        running <= 1'b0;
        folding <= 1'b1;
      end
    end else if (folding) begin
      for (int i = 0; i < 8; i++) hs[i] <= hs[i] + v[i];
      folding <= 1'b0;
    end
  end

  assign hash_out = hs;
  assign busy     = running | folding;

`ifndef SYNTHESIS
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(running && folding))
    else $error("run and fold overlap");
  a_fold_after: assert property (@(posedge clk) disable iff (rst)
    (running && rnd == 6'd63) |=> folding)
    else $error("fold missing");
  a_fold_one: assert property (@(posedge clk) disable iff (rst) folding |=> !folding)
    else $error("fold too long");
`endif

endmodule

/* src/sha224_stream_hasher.sv */
// SHA-224 stream hasher top level: byte packer, padding sequencer, digest output.
// Depends on sha224_pkg and sha224_core.
//
// A byte item is taken while in_ready is high; the byte that fills a 64-byte
// block holds the input off while the shared round unit runs the 64 rounds
// and the fold, so no new item is taken until that block is compressed.
// An end_of_message item runs one or two more compressions (two when 56 or
// more bytes sit in the last block) and then offers the seven digest words,
// index 0 first, each held until taken.
module sha224_stream_hasher import sha224_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_COMP, S_PAD, S_PAD2, S_LEN, S_LAST, S_OUT
  } state_t;

  state_t     state;
  word_t      blk [16];
  logic [5:0] fill;
  logic [60:0] len;
  logic       eom_pend;
  logic       core_start, core_init, core_busy;
  word_t      hash [8];
  logic [63:0] bits;

  sha224_core u_core (
    .clk(clk), .rst(rst), .start(core_start), .init(core_init),
    .block_in(blk), .hash_out(hash), .busy(core_busy)
  );

  assign in_ready = (state == S_IDLE);
  assign bits     = {len, 3'b000};

  always_comb begin
    core_start = 1'b0;
    core_init  = 1'b0;
    if (state == S_IDLE && in_valid && byte_valid && fill == 6'd63) core_start = 1'b1;
    if ((state == S_PAD || state == S_LEN) && !core_busy) core_start = 1'b1;
    if (state == S_OUT && out_ready && word_index == 3'd6) core_init = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      len       <= '0;
      eom_pend  <= 1'b0;
      out_valid <= 1'b0;
      word_index <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            eom_pend <= end_of_message;
            if (byte_valid) begin
              blk[fill[5:2]][8*(3-fill[1:0]) +: 8] <= data_byte;
              len  <= len + 61'd1;
              fill <= fill + 6'd1;
            end
            if (byte_valid && fill == 6'd63) begin
              state <= S_COMP;
            end else if (end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_COMP: begin
          if (!core_busy) state <= eom_pend ? S_PAD : S_IDLE;
        end
        S_PAD: begin
          // mark byte plus zeros after it; length goes in unless it overflows
          for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 4; j++) begin
              if (6'(4*i + j) == fill) blk[i][8*(3-j) +: 8] <= PAD_MARK;
              else if (6'(4*i + j) > fill) blk[i][8*(3-j) +: 8] <= 8'h00;
            end
          end
          if (fill < LEN_POS) begin
            blk[14] <= bits[63:32];
            blk[15] <= bits[31:0];
            state   <= S_LAST;
          end else begin
            state <= S_PAD2;
          end
        end
        S_PAD2: begin
          // the first pad block is read during its rounds; refill after the fold
          if (!core_busy) begin
            for (int i = 0; i < 14; i++) blk[i] <= '0;
            blk[14] <= bits[63:32];
            blk[15] <= bits[31:0];
            state   <= S_LEN;
          end
        end
        S_LEN: begin
          state <= S_LAST;
        end
        S_LAST: begin
          if (!core_busy && !core_start) begin
            state      <= S_OUT;
            out_valid  <= 1'b1;
            word_index <= '0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (word_index == 3'd6) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
              fill      <= '0;
              len       <= '0;
              eom_pend  <= 1'b0;
            end else begin
              word_index <= word_index + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign digest_word = hash[word_index];
  assign last_word   = (word_index == 3'd6);

`ifndef SYNTHESIS
  a_out_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT))
    else $error("output outside digest phase");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    core_busy |-> !in_ready)
    else $error("ready while compressing");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (word_index <= 3'd6))
    else $error("bad word index");
`endif

endmodule

/* test/sha224_stream_hasher_tb.sv */
`timescale 1ns / 100ps
// Testbench for sha224_stream_hasher: drives byte items, predicts SHA-224 digests
// with a local software hash, checks each digest word. Depends on sha224_pkg and sha224_stream_hasher.
module sha224_stream_hasher_tb;
  import sha224_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  // predictor state
  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [31:0] sched [16];
  logic [5:0]  fill;
  logic [60:0] nbytes;

  digest_item_t digest_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;

  sha224_stream_hasher dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .byte_valid(byte_valid), .end_of_message(end_of_message),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] v [8];
    logic [31:0] w, a, b, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = blk[t];
      end else begin
        a = sched[(t - 2) & 15];
        b = sched[(t - 15) & 15];
        w = (ror(a, 17) ^ ror(a, 19) ^ (a >> 10)) + sched[(t - 7) & 15]
            + (ror(b, 7) ^ ror(b, 18) ^ (b >> 3)) + sched[t & 15];
      end
      sched[t & 15] = w;
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[0] = t1 + t2;
      v[4] = v[4] + t1;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic place_byte(input int pos, input logic [7:0] b);
    blk[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
  endtask

  task automatic predict_item(input logic [7:0] d, input logic bv, input logic eom);
    logic [63:0] bits;
    int pos;
    digest_item_t di;
    if (bv) begin
      place_byte(fill, d);
      nbytes = nbytes + 1;
      fill = fill + 1;
      if (fill == 0) compress_blk();
    end
    if (!eom) return;
    pos = fill;
    place_byte(pos, PAD_MARK);
    for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
    if (pos >= LEN_POS) begin
      compress_blk();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    bits = {nbytes, 3'b000};
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_blk();
    for (int i = 0; i < 7; i++) begin
      di.word = chain[i];
      di.idx = 3'(i);
      di.last = (i == 6);
      digest_q.push_back(di);
    end
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    fill = '0;
    nbytes = '0;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // sends one item; prediction happens at acceptance; valid stays up for the next one
  task automatic send_item(input logic [7:0] d, input logic bv, input logic eom);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    byte_valid <= bv;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    predict_item(d, bv, eom);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    else send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("digest word with none expected");
        end else begin
          digest_item_t e;
          e = digest_q.pop_front();
          if (digest_word !== e.word)
            report_mismatch($sformatf("word %h expected %h", digest_word, e.word));
          if (word_index !== e.idx)
            report_mismatch($sformatf("index %0d expected %0d", word_index, e.idx));
          if (last_word !== e.last)
            report_mismatch($sformatf("last %b expected %b", last_word, e.last));
        end
      end
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b1);               // empty message
    send_item(8'h61, 1'b1, 1'b0);               // "abc"
    send_item(8'h00, 1'b0, 1'b0);               // ignored byte in the middle
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);               // end with no valid byte
    wait_drain();
  endtask

  task automatic test_block_edges();
    send_message(56);                           // padding spills to second block
    send_message(64);                           // byte fills a block
    for (int i = 0; i < 64; i++) send_item(8'($urandom), 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);               // full block then empty end
    wait_drain();
  endtask

  task automatic test_random(input int n_items);
    int sent = 0;
    int len;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom), ($urandom_range(7) != 0), 1'b0);
        sent++;
      end
      send_item(8'($urandom), 1'($urandom), 1'b1);
      sent++;
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
      end
      begin
        for (int m = 0; m < 6; m++) send_message($urandom_range(10));
        in_valid <= 1'b0;
        @(posedge clk);
      end
    join
    wait_drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
    for (int i = 0; i < 16; i++) begin
      blk[i] = '0;
      sched[i] = '0;
    end
    fill = '0;
    nbytes = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_block_edges();
    test_random(25);
    send_idle_pct = 84;
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 84;
    test_random(20);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    test_random(20);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
